// ===== rtl/tbgc_pkg.sv =====
// Shared types, gesture codes and register defaults for the two-button gesture classifier.
package tbgc_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 4;

    typedef logic [TIME_W-1:0] time_ms_t;
    typedef logic [CFG_W-1:0]  cfg_ms_t;
    typedef logic [CODE_W-1:0] gesture_t;

    // Gesture codes
    localparam gesture_t G_NONE        = 3'd0;
    localparam gesture_t G_A_SHORT     = 3'd1;
    localparam gesture_t G_A_LONG      = 3'd2;
    localparam gesture_t G_B_SHORT     = 3'd3;
    localparam gesture_t G_B_LONG      = 3'd4;
    localparam gesture_t G_CHORD_SHORT = 3'd5;
    localparam gesture_t G_CHORD_LONG  = 3'd6;

    // Register word indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_CHORD_LONG = 2'd2;

    // Register reset values
    localparam cfg_ms_t DEBOUNCE_RST   = 16'd50;
    localparam cfg_ms_t LONG_PRESS_RST = 16'd600;
    localparam cfg_ms_t CHORD_LONG_RST = 16'd1500;

endpackage

// ===== rtl/two_button_gesture_classifier.sv =====
// Top level: two-button short/long/chord gesture classifier with APB register port.
// A poll is registered in the input stage, then in the output stage that drives m_valid.
// Throughput: one poll per cycle unless the output stalls; state updates on advance.
// s_ready stays high while the input stage is empty or moves on in the same cycle.
// Reset (aresetn low, synchronous): held and chord flags, start times and both
// pipeline valids clear; the three timing registers return to 50, 600 and 1500 ms.
module two_button_gesture_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    // poll input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_a_pressed,
    input  logic                            s_b_pressed,
    input  logic [tbgc_pkg::TIME_W-1:0]     s_now_ms,
    // gesture output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tbgc_pkg::CODE_W-1:0]     m_gesture,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbgc_pkg::APB_AW-1:0]     paddr,
    input  logic [tbgc_pkg::APB_DW-1:0]     pwdata,
    output logic [tbgc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    // Configuration registers
    tbgc_pkg::cfg_ms_t debounce_reg;
    tbgc_pkg::cfg_ms_t long_press_reg;
    tbgc_pkg::cfg_ms_t chord_long_reg;

    // Input stage
    logic                   in_valid_reg;
    logic                   in_a_reg;
    logic                   in_b_reg;
    tbgc_pkg::time_ms_t     in_now_reg;

    // Output stage
    logic                   out_valid_reg;
    tbgc_pkg::gesture_t     out_gesture_reg;

    // Classifier state
    logic                   a_held_reg, a_held_next;
    logic                   b_held_reg, b_held_next;
    tbgc_pkg::time_ms_t     a_start_reg, a_start_next;
    tbgc_pkg::time_ms_t     b_start_reg, b_start_next;
    logic                   chord_active_reg, chord_active_next;
    logic                   chord_done_reg, chord_done_next;
    tbgc_pkg::time_ms_t     chord_start_reg, chord_start_next;
    tbgc_pkg::gesture_t     gesture_next;

    tbgc_pkg::time_ms_t     chord_elapsed;
    tbgc_pkg::time_ms_t     a_elapsed;
    tbgc_pkg::time_ms_t     b_elapsed;
    tbgc_pkg::time_ms_t     debounce_ext;
    tbgc_pkg::time_ms_t     long_press_ext;
    tbgc_pkg::time_ms_t     chord_long_ext;

    logic                   advance;
    logic                   cfg_wr;

    // Handshake: the input stage moves on when the output stage is free or drains
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_gesture = out_gesture_reg;

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= tbgc_pkg::DEBOUNCE_RST;
            long_press_reg <= tbgc_pkg::LONG_PRESS_RST;
            chord_long_reg <= tbgc_pkg::CHORD_LONG_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tbgc_pkg::REG_DEBOUNCE:   debounce_reg   <= pwdata[tbgc_pkg::CFG_W-1:0];
                tbgc_pkg::REG_LONG_PRESS: long_press_reg <= pwdata[tbgc_pkg::CFG_W-1:0];
                tbgc_pkg::REG_CHORD_LONG: chord_long_reg <= pwdata[tbgc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tbgc_pkg::REG_DEBOUNCE:
                prdata = {{(tbgc_pkg::APB_DW-tbgc_pkg::CFG_W){1'b0}}, debounce_reg};
            tbgc_pkg::REG_LONG_PRESS:
                prdata = {{(tbgc_pkg::APB_DW-tbgc_pkg::CFG_W){1'b0}}, long_press_reg};
            tbgc_pkg::REG_CHORD_LONG:
                prdata = {{(tbgc_pkg::APB_DW-tbgc_pkg::CFG_W){1'b0}}, chord_long_reg};
            default:
                prdata = '0;
        endcase
    end

    assign debounce_ext   = {{(tbgc_pkg::TIME_W-tbgc_pkg::CFG_W){1'b0}}, debounce_reg};
    assign long_press_ext = {{(tbgc_pkg::TIME_W-tbgc_pkg::CFG_W){1'b0}}, long_press_reg};
    assign chord_long_ext = {{(tbgc_pkg::TIME_W-tbgc_pkg::CFG_W){1'b0}}, chord_long_reg};

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_a_reg   <= s_a_pressed;
            in_b_reg   <= s_b_pressed;
            in_now_reg <= s_now_ms;
        end
    end

    // Classification of the poll in the input stage
    always_comb begin
        a_held_next       = a_held_reg;
        b_held_next       = b_held_reg;
        a_start_next      = a_start_reg;
        b_start_next      = b_start_reg;
        chord_active_next = chord_active_reg;
        chord_done_next   = chord_done_reg;
        chord_start_next  = chord_start_reg;
        gesture_next      = tbgc_pkg::G_NONE;

        // latch press times on rising presses
        if (in_a_reg && !a_held_reg) begin
            a_start_next = in_now_reg;
            a_held_next  = 1'b1;
        end
        if (in_b_reg && !b_held_reg) begin
            b_start_next = in_now_reg;
            b_held_next  = 1'b1;
        end

        // chord starts at the smaller latched time (plain unsigned compare)
        if (in_a_reg && in_b_reg && !chord_active_reg) begin
            chord_active_next = 1'b1;
            chord_done_next   = 1'b0;
            chord_start_next  = (a_start_next < b_start_next) ? a_start_next : b_start_next;
        end

        chord_elapsed = in_now_reg - chord_start_next;
        a_elapsed     = in_now_reg - a_start_reg;
        b_elapsed     = in_now_reg - b_start_reg;

        if (in_a_reg && in_b_reg) begin
            // both held: chord long fires once
            if (!chord_done_next && (chord_elapsed >= chord_long_ext)) begin
                chord_done_next = 1'b1;
                gesture_next    = tbgc_pkg::G_CHORD_LONG;
            end
        end else if (chord_active_reg) begin
            // chord ends only when both are up; partial release reports nothing
            if (!in_a_reg && !in_b_reg) begin
                chord_active_next = 1'b0;
                chord_done_next   = 1'b0;
                a_held_next       = 1'b0;
                b_held_next       = 1'b0;
                if (!chord_done_reg && (chord_elapsed >= debounce_ext)) begin
                    gesture_next = tbgc_pkg::G_CHORD_SHORT;
                end
            end
        end else begin
            // single releases, A first; B waits if A reported
            if (!in_a_reg && a_held_reg) begin
                a_held_next = 1'b0;
                if (a_elapsed >= debounce_ext) begin
                    gesture_next = (a_elapsed >= long_press_ext) ? tbgc_pkg::G_A_LONG
                                                                 : tbgc_pkg::G_A_SHORT;
                end
            end
            if ((gesture_next == tbgc_pkg::G_NONE) && !in_b_reg && b_held_reg) begin
                b_held_next = 1'b0;
                if (b_elapsed >= debounce_ext) begin
                    gesture_next = (b_elapsed >= long_press_ext) ? tbgc_pkg::G_B_LONG
                                                                 : tbgc_pkg::G_B_SHORT;
                end
            end
        end
    end

    // State update as the transaction leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_held_reg       <= 1'b0;
            b_held_reg       <= 1'b0;
            a_start_reg      <= '0;
            b_start_reg      <= '0;
            chord_active_reg <= 1'b0;
            chord_done_reg   <= 1'b0;
            chord_start_reg  <= '0;
        end else if (advance) begin
            a_held_reg       <= a_held_next;
            b_held_reg       <= b_held_next;
            a_start_reg      <= a_start_next;
            b_start_reg      <= b_start_next;
            chord_active_reg <= chord_active_next;
            chord_done_reg   <= chord_done_next;
            chord_start_reg  <= chord_start_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_gesture_reg <= gesture_next;
        end
    end

`ifndef SYNTHESIS
    // chord long can only be marked inside an active chord
    assert property (@(posedge aclk) disable iff (!aresetn)
        chord_done_reg |-> chord_active_reg)
        else $error("chord long marked without an active chord");

    // an active chord keeps both held flags set
    assert property (@(posedge aclk) disable iff (!aresetn)
        chord_active_reg |-> (a_held_reg && b_held_reg))
        else $error("chord active while a button is not held");

    // an accepted poll lands in the input stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted poll lost at the input stage");

    // delivered codes are in the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gesture <= tbgc_pkg::G_CHORD_LONG))
        else $error("undefined gesture code on output");

    // a stalled input stage does not move state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> $stable(a_start_reg))
        else $error("state changed while the output stage was stalled");
`endif

endmodule

// ===== tb/two_button_gesture_checker.sv =====
// Checker for the gesture classifier: predicts each poll's gesture and compares the results.
`timescale 1ns / 100ps
module two_button_gesture_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_a_pressed,
    input  logic                            s_b_pressed,
    input  logic [tbgc_pkg::TIME_W-1:0]     s_now_ms,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [tbgc_pkg::CODE_W-1:0]     m_gesture,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbgc_pkg::APB_AW-1:0]     paddr,
    input  logic [tbgc_pkg::APB_DW-1:0]     pwdata,
    input  logic                            pready,
    output int                              error_count,
    output int                              pending_count
);

    // timing registers as the block should hold them
    tbgc_pkg::cfg_ms_t  debounce_cfg;
    tbgc_pkg::cfg_ms_t  long_cfg;
    tbgc_pkg::cfg_ms_t  chord_cfg;

    // button and chord tracking
    logic               a_down;
    logic               b_down;
    logic               chord_on;
    logic               chord_fired;
    tbgc_pkg::time_ms_t a_t0;
    tbgc_pkg::time_ms_t b_t0;
    tbgc_pkg::time_ms_t chord_t0;

    tbgc_pkg::gesture_t expected_gestures[$];
    int                 mismatches = 0;
    int                 waiting = 0;
    int                 result_idx = 0;

    assign error_count   = mismatches;
    assign pending_count = waiting;

    task automatic report_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    // gesture for one poll; updates the tracked button state
    function automatic tbgc_pkg::gesture_t classify_poll(input logic ap, input logic bp,
                                                         input tbgc_pkg::time_ms_t now);
        tbgc_pkg::gesture_t g;
        tbgc_pkg::time_ms_t hold;
        g = tbgc_pkg::G_NONE;

        // latch press times on the first poll a button is seen down
        if (ap && !a_down) begin
            a_t0   = now;
            a_down = 1'b1;
        end
        if (bp && !b_down) begin
            b_t0   = now;
            b_down = 1'b1;
        end

        if (ap && bp) begin
            // chord held: plain unsigned minimum of the two starts, no wrap handling
            if (!chord_on) begin
                chord_on    = 1'b1;
                chord_fired = 1'b0;
                chord_t0    = (a_t0 < b_t0) ? a_t0 : b_t0;
            end
            hold = now - chord_t0;
            if (!chord_fired && hold >= chord_cfg) begin
                chord_fired = 1'b1;
                g = tbgc_pkg::G_CHORD_LONG;
            end
        end else if (chord_on) begin
            // one button up inside a chord reports nothing; both up ends it
            if (!ap && !bp) begin
                hold = now - chord_t0;
                if (!chord_fired && hold >= debounce_cfg)
                    g = tbgc_pkg::G_CHORD_SHORT;
                chord_on    = 1'b0;
                chord_fired = 1'b0;
                a_down      = 1'b0;
                b_down      = 1'b0;
            end
        end else begin
            // single releases, A first; B waits if A produced an event
            if (!ap && a_down) begin
                hold   = now - a_t0;
                a_down = 1'b0;
                if (hold >= debounce_cfg)
                    g = (hold >= long_cfg) ? tbgc_pkg::G_A_LONG : tbgc_pkg::G_A_SHORT;
            end
            if (g == tbgc_pkg::G_NONE && !bp && b_down) begin
                hold   = now - b_t0;
                b_down = 1'b0;
                if (hold >= debounce_cfg)
                    g = (hold >= long_cfg) ? tbgc_pkg::G_B_LONG : tbgc_pkg::G_B_SHORT;
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin
        tbgc_pkg::gesture_t want;
        if (!aresetn) begin
            debounce_cfg = tbgc_pkg::DEBOUNCE_RST;
            long_cfg     = tbgc_pkg::LONG_PRESS_RST;
            chord_cfg    = tbgc_pkg::CHORD_LONG_RST;
            a_down       = 1'b0;
            b_down       = 1'b0;
            chord_on     = 1'b0;
            chord_fired  = 1'b0;
            a_t0         = '0;
            b_t0         = '0;
            chord_t0     = '0;
            expected_gestures.delete();
            waiting <= 0;
        end else begin
            // register writes, upper data bits dropped
            if (psel && penable && pwrite && pready) begin
                case (paddr[tbgc_pkg::APB_AW-1:2])
                    tbgc_pkg::REG_DEBOUNCE:   debounce_cfg = pwdata[tbgc_pkg::CFG_W-1:0];
                    tbgc_pkg::REG_LONG_PRESS: long_cfg     = pwdata[tbgc_pkg::CFG_W-1:0];
                    tbgc_pkg::REG_CHORD_LONG: chord_cfg    = pwdata[tbgc_pkg::CFG_W-1:0];
                    default: ;
                endcase
            end

            // result transactions against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_gestures.size() == 0) begin
                    report_mismatch($sformatf("gesture %0d with nothing expected", m_gesture));
                end else begin
                    want = expected_gestures.pop_front();
                    if (m_gesture !== want)
                        report_mismatch($sformatf("result %0d: gesture %0d, expected %0d",
                                                  result_idx, m_gesture, want));
                    result_idx++;
                end
            end

            // poll transactions
            if (s_valid && s_ready)
                expected_gestures.push_back(classify_poll(s_a_pressed, s_b_pressed, s_now_ms));

            waiting <= expected_gestures.size();
        end
    end

endmodule

// ===== tb/two_button_gesture_classifier_tb.sv =====
// Testbench top: drives polls, register writes and result back-pressure, and gives the verdict.
`timescale 1ns / 100ps
module two_button_gesture_classifier_tb;

    localparam int         CYCLE_LIMIT = 100000;
    localparam int         PHASES      = 6;
    localparam int         PHASE_POLLS = 140;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic                               s_a_pressed;
    logic                               s_b_pressed;
    logic [tbgc_pkg::TIME_W-1:0]        s_now_ms;
    logic                               m_valid;
    logic                               m_ready;
    logic [tbgc_pkg::CODE_W-1:0]        m_gesture;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [tbgc_pkg::APB_AW-1:0]        paddr;
    logic [tbgc_pkg::APB_DW-1:0]        pwdata;
    logic [tbgc_pkg::APB_DW-1:0]        prdata;
    logic                               pready;

    int                 error_count;
    int                 pending_count;
    int                 cycle_count = 0;
    int                 gap_max = 3;
    int                 stall_max = 3;
    int                 polls_sent = 0;
    tbgc_pkg::time_ms_t clock_ms = '0;
    tbgc_pkg::time_ms_t deb_set;
    tbgc_pkg::time_ms_t long_set;
    tbgc_pkg::time_ms_t chord_set;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    two_button_gesture_classifier dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_a_pressed (s_a_pressed),
        .s_b_pressed (s_b_pressed),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_gesture   (m_gesture),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    two_button_gesture_checker gesture_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_a_pressed   (s_a_pressed),
        .s_b_pressed   (s_b_pressed),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gesture     (m_gesture),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // one poll transaction after a random gap
    task automatic send_poll(input logic a, input logic b, input tbgc_pkg::time_ms_t now);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_a_pressed <= a;
        s_b_pressed <= b;
        s_now_ms    <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        polls_sent++;
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [tbgc_pkg::APB_DW-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop sending and wait for every outstanding gesture
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // timing registers are only touched with the pipeline empty; junk in the upper bits
    task automatic set_timing(input tbgc_pkg::cfg_ms_t d, input tbgc_pkg::cfg_ms_t l,
                              input tbgc_pkg::cfg_ms_t c);
        logic [15:0] junk;
        wait_drained();
        junk = 16'($urandom);
        apb_write(tbgc_pkg::REG_DEBOUNCE, {junk, d});
        junk = 16'($urandom);
        apb_write(tbgc_pkg::REG_LONG_PRESS, {junk, l});
        junk = 16'($urandom);
        apb_write(tbgc_pkg::REG_CHORD_LONG, {junk, c});
        deb_set   = {16'd0, d};
        long_set  = {16'd0, l};
        chord_set = {16'd0, c};
    endtask

    // hold lengths clustered on the current thresholds
    function automatic tbgc_pkg::time_ms_t pick_hold();
        tbgc_pkg::time_ms_t h;
        case ($urandom_range(0, 10))
            0:       h = '0;
            1:       h = deb_set - 1;
            2:       h = deb_set;
            3:       h = long_set - 1;
            4:       h = long_set;
            5:       h = chord_set - 1;
            6:       h = chord_set;
            7:       h = $urandom_range(0, 100);
            8:       h = $urandom_range(0, 3000);
            9:       h = $urandom_range(0, 70000);
            default: h = $urandom;
        endcase
        return h;
    endfunction

    // a well-formed single press or chord with random timing
    task automatic play_gesture();
        int                 kind;
        int                 mids;
        int                 j;
        logic               keep_a;
        tbgc_pkg::time_ms_t t0;
        tbgc_pkg::time_ms_t t;
        tbgc_pkg::time_ms_t hold;
        tbgc_pkg::time_ms_t lag;
        kind = $urandom_range(0, 9);
        mids = $urandom_range(0, 3);
        t0   = clock_ms + $urandom_range(1, 40);
        hold = pick_hold();
        lag  = $urandom_range(0, 30);
        if (kind < 6) begin
            // single button, A or B
            keep_a = (kind < 3);
            send_poll(keep_a, !keep_a, t0);
            for (j = 1; j <= mids; j++)
                send_poll(keep_a, !keep_a, t0 + (hold / (mids + 1)) * j);
            t = t0 + hold;
            send_poll(1'b0, 1'b0, t);
        end else begin
            // chord, either button first or both together
            case ($urandom_range(0, 2))
                0: begin
                    send_poll(1'b1, 1'b0, t0);
                    send_poll(1'b1, 1'b1, t0 + lag);
                end
                1: begin
                    send_poll(1'b0, 1'b1, t0);
                    send_poll(1'b1, 1'b1, t0 + lag);
                end
                default: send_poll(1'b1, 1'b1, t0);
            endcase
            for (j = 1; j <= mids; j++) begin
                t = t0 + lag + (hold / (mids + 1)) * j;
                if ($urandom_range(0, 3) == 0) begin
                    // partial release and re-press inside the chord
                    keep_a = ($urandom_range(0, 1) == 1);
                    send_poll(keep_a, !keep_a, t);
                end
                send_poll(1'b1, 1'b1, t);
            end
            t = t0 + lag + hold;
            if ($urandom_range(0, 2) == 0) begin
                keep_a = ($urandom_range(0, 1) == 1);
                send_poll(keep_a, !keep_a, t);
                t = t + $urandom_range(0, 40);
            end
            send_poll(1'b0, 1'b0, t);
        end
        clock_ms = t;
    endtask

    // random levels and time steps
    task automatic play_noise();
        int                 n;
        int                 k;
        tbgc_pkg::time_ms_t t;
        n = $urandom_range(1, 4);
        t = clock_ms;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0)
                t = t + pick_hold();
            else
                t = t + $urandom_range(0, 60);
            send_poll(($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1), t);
        end
        clock_ms = t;
    endtask

    // directed polls at the default thresholds (50 / 600 / 1500)
    task automatic run_directed();
        send_poll(1'b0, 1'b0, 32'd0);
        // release under debounce
        send_poll(1'b1, 1'b0, 32'd100);
        send_poll(1'b0, 1'b0, 32'd120);
        // A short exactly at debounce, A long exactly at long press
        send_poll(1'b1, 1'b0, 32'd200);
        send_poll(1'b0, 1'b0, 32'd250);
        send_poll(1'b1, 1'b0, 32'd300);
        send_poll(1'b0, 1'b0, 32'd900);
        // B one below long, then B long
        send_poll(1'b0, 1'b1, 32'd1000);
        send_poll(1'b0, 1'b0, 32'd1599);
        send_poll(1'b0, 1'b1, 32'd2000);
        send_poll(1'b0, 1'b0, 32'd2600);
        // chord long fires once while held, nothing on release
        send_poll(1'b1, 1'b0, 32'd3000);
        send_poll(1'b1, 1'b1, 32'd3010);
        send_poll(1'b1, 1'b1, 32'd4499);
        send_poll(1'b1, 1'b1, 32'd4500);
        send_poll(1'b0, 1'b0, 32'd4700);
        // partial release, re-press keeps the old start, then chord short
        send_poll(1'b1, 1'b1, 32'd5000);
        send_poll(1'b0, 1'b1, 32'd5020);
        send_poll(1'b1, 1'b1, 32'd5030);
        send_poll(1'b0, 1'b0, 32'd5060);
        // chord across the wrap: start is the smaller raw value
        send_poll(1'b1, 1'b0, 32'hFFFF_FFF0);
        send_poll(1'b1, 1'b1, 32'h0000_0010);
        send_poll(1'b0, 1'b0, 32'h0000_0080);
        // single press across the wrap from the top timestamp
        send_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 1'b0, 32'h0000_0031);
        clock_ms = 32'h0000_0100;
    endtask

    // result side: random stall before taking each gesture
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int phase;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_a_pressed <= 1'b0;
        s_b_pressed <= 1'b0;
        s_now_ms    <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        deb_set     = {16'd0, tbgc_pkg::DEBOUNCE_RST};
        long_set    = {16'd0, tbgc_pkg::LONG_PRESS_RST};
        chord_set   = {16'd0, tbgc_pkg::CHORD_LONG_RST};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_timing(16'd0, 16'd0, 16'd0);
                1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_timing(tbgc_pkg::cfg_ms_t'($urandom_range(0, 100)),
                              tbgc_pkg::cfg_ms_t'($urandom_range(0, 1000)),
                              tbgc_pkg::cfg_ms_t'($urandom_range(0, 2500)));
                // long threshold below debounce
                3: set_timing(16'd500, 16'd100, 16'd300);
                4: set_timing(tbgc_pkg::cfg_ms_t'($urandom), tbgc_pkg::cfg_ms_t'($urandom),
                              tbgc_pkg::cfg_ms_t'($urandom));
                default: begin
                    set_timing(tbgc_pkg::DEBOUNCE_RST, tbgc_pkg::LONG_PRESS_RST,
                               tbgc_pkg::CHORD_LONG_RST);
                    // write to an unmapped word must change nothing
                    apb_write(REG_UNUSED, $urandom);
                end
            endcase
            gap_max    = (phase % 3 == 1) ? 0 : 3;
            stall_max  = (phase % 3 == 2) ? 0 : 3;
            polls_sent = 0;
            while (polls_sent < PHASE_POLLS) begin
                if ($urandom_range(0, 19) == 0)
                    clock_ms = $urandom;
                if ($urandom_range(0, 4) == 0)
                    play_noise();
                else
                    play_gesture();
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== two_button_gesture_classifier.f =====
rtl/tbgc_pkg.sv
rtl/two_button_gesture_classifier.sv
tb/two_button_gesture_checker.sv
tb/two_button_gesture_classifier_tb.sv
